@@ rtl/core/ledsu_pkg.sv @@
// Package for the indicator LED set/update core.
// Holds the request and LED codes, the command byte constants and the
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package ledsu_pkg;

	typedef enum logic {
		REQ_SET    = 1'b0,
		REQ_UPDATE = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		LED_YELLOW = 2'd0,
		LED_GREEN  = 2'd1,
		LED_RED    = 2'd2,
		LED_NONE   = 2'd3
	} led_index_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} ctrl_state_t;

	localparam logic [5:0] ALL_ON_BITS    = 6'h15;
	localparam logic [5:0] ALL_BLINK_BITS = 6'h2A;
	localparam logic [7:0] LED_CODE_BASE  = 8'h30;
	localparam logic [7:0] LED_CMD_ON     = 8'h04;
	localparam logic [7:0] LED_CMD_BLINK  = 8'h08;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic set_led;
		logic start_update;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic changed;
		logic has_diff;
		logic remain;
		logic emit_last;
	} dp_stat_t;

	function automatic logic [5:0] pair_mask(input led_index_t idx);
		logic [5:0] m;
		unique case (idx)
			LED_YELLOW: m = 6'h03;
			LED_GREEN:  m = 6'h0C;
			LED_RED:    m = 6'h30;
			LED_NONE:   m = 6'h00;
			default:    m = 6'h00;
		endcase
		return m;
	endfunction

endpackage

@@ rtl/core/indicator_led_set_update_core.sv @@
// Top level of the indicator LED set/update core.
// Joins ledsu_ctrl and ledsu_dp; depends on ledsu_pkg.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | req_type, led_index, want_on, want_blink,
//          |                    | want_invert
//  out     | out_valid/out_stall| command, last
//
// Set and update beats are taken in the idle state; after an update, one command
// per differing LED (up to three) follows, with in_stall high in the emit state.
// Each command leaves through a single output register, so a stalled output
// only delays emission; the next input beat is taken once the last command is
// loaded. Reset (arst_n low) clears all LED bits, the changed flag and valids.
`timescale 1ns / 1ps

module indicator_led_set_update_core import ledsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic [1:0] led_index,
	input  logic       want_on,
	input  logic       want_blink,
	input  logic       want_invert,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] command,
	output logic       last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy;

	ledsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.busy      (busy),
		.cmd       (cmd)
	);

	ledsu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.led_index   (led_index),
		.want_on     (want_on),
		.want_blink  (want_blink),
		.want_invert (want_invert),
		.stat        (stat),
		.command     (command),
		.last        (last)
	);

	// While emitting, at least one LED must still be marked different.
	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> stat.remain)
		else $error("emit state with empty difference mask");

	// A valid command always carries an LED code and a sane state field.
	a_cmd_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (command[7:4] == 4'h3) && (command[1:0] != 2'b00)
		&& (command[3:2] != 2'b11))
		else $error("malformed command byte");

	// After a beat that is not the last, emission continues.
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (busy || out_valid))
		else $error("update ended without a last beat");

	// No update may start while commands of an earlier one are pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_update |-> !busy && !stat.remain)
		else $error("update started while emitting");

endmodule

@@ rtl/core/ledsu_dp.sv @@
// Datapath of the indicator LED set/update core: pending and shown LED
// bits, changed flag, per-LED difference mask and the output beat register.
// Depends on ledsu_pkg.
`timescale 1ns / 1ps

module ledsu_dp import ledsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  logic [1:0] led_index,
	input  logic       want_on,
	input  logic       want_blink,
	input  logic       want_invert,
	output dp_stat_t   stat,
	output logic [7:0] command,
	output logic       last
);

	logic [5:0] pending_q;
	logic [5:0] shown_q;
	logic       changed_q;
	logic [2:0] diff_q;
	logic [7:0] command_q;
	logic       last_q;

	logic [5:0] mask;
	logic [5:0] sel;
	logic [5:0] pending_nxt;
	logic [5:0] xdiff;
	logic [2:0] diff_low;
	logic [1:0] emit_led;
	logic [1:0] led_bits;
	logic [7:0] emit_cmd;

	always_comb begin
		mask = pair_mask(led_index_t'(led_index));
		if (want_invert) begin
			sel = (pending_q & mask) ^ (mask & ALL_ON_BITS);
		end else if (want_on) begin
			sel = mask & ALL_ON_BITS;
		end else if (want_blink) begin
			sel = mask;
		end else begin
			sel = 6'h00;
		end
		pending_nxt = (pending_q & ~mask) | sel;
	end

	assign xdiff = pending_q ^ shown_q;

	// The lowest LED still marked different is emitted first.
	always_comb begin
		diff_low = diff_q & (~diff_q + 3'd1);
		if (diff_q[0]) begin
			emit_led = LED_YELLOW;
		end else if (diff_q[1]) begin
			emit_led = LED_GREEN;
		end else begin
			emit_led = LED_RED;
		end
		case (emit_led)
			LED_YELLOW: led_bits = pending_q[1:0];
			LED_GREEN:  led_bits = pending_q[3:2];
			default:    led_bits = pending_q[5:4];
		endcase
		emit_cmd = LED_CODE_BASE | ({6'd0, emit_led} + 8'd1);
		if (led_bits[0]) begin
			emit_cmd = emit_cmd | (led_bits[1] ? LED_CMD_BLINK : LED_CMD_ON);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			shown_q   <= '0;
			changed_q <= 1'b0;
			diff_q    <= '0;
		end else begin
			if (cmd.set_led) begin
				pending_q <= pending_nxt;
				if (pending_nxt != shown_q) begin
					changed_q <= 1'b1;
				end
			end
			if (cmd.start_update) begin
				changed_q <= 1'b0;
				shown_q   <= pending_q;
				diff_q    <= {|xdiff[5:4], |xdiff[3:2], |xdiff[1:0]};
			end
			if (cmd.emit) begin
				diff_q <= diff_q & ~diff_low;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			command_q <= emit_cmd;
			last_q    <= ((diff_q & ~diff_low) == 3'd0);
		end
	end

	assign stat.changed   = changed_q;
	assign stat.has_diff  = |xdiff;
	assign stat.remain    = |diff_q;
	assign stat.emit_last = ((diff_q & ~diff_low) == 3'd0);

	assign command = command_q;
	assign last    = last_q;

endmodule

@@ rtl/core/ledsu_ctrl.sv @@
// Controller of the indicator LED set/update core: idle/emit state machine
// and the output valid flag. Drives the datapath through dp_cmd_t.
// Depends on ledsu_pkg.
`timescale 1ns / 1ps

module ledsu_ctrl import ledsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     req_type,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output logic     in_stall,
	output logic     out_valid,
	output logic     busy,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= cmd.emit || (out_valid_q && out_stall);
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (req_type_t'(req_type) == REQ_SET) begin
						cmd.set_led = 1'b1;
					end else if (stat.changed) begin
						cmd.start_update = 1'b1;
						if (stat.has_diff) begin
							state_nxt = ST_EMIT;
						end
					end
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
	assign busy      = (state_q == ST_EMIT);

endmodule
